>>> hdl/selm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// selm_pkg
// Shared types and constants of the segment edit list mapper.
// ---------------------------------------------------------------------------
package selm_pkg;

	localparam int MAX_SEGMENTS = 256;
	localparam int IDX_W        = $clog2(MAX_SEGMENTS);
	localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);

	localparam int FRAME_W      = 31;
	localparam int SEG_HELD_W   = 9;
	localparam int ENTRY_W      = 2 * FRAME_W;

	localparam int S_TDATA_W    = 136;
	localparam int S_TUSER_W    = 2;
	localparam int M_TDATA_W    = 72;
	localparam int M_TUSER_W    = 3;
	localparam int CFG_INDEX_W  = 1;
	localparam int CFG_DATA_W   = 31;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_SRC_COUNT = 1'b0,
		CFG_EXACT     = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		K_CLEAR   = 2'd0,
		K_APPEND  = 2'd1,
		K_OUT2SRC = 2'd2,
		K_SRC2OUT = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_RANGE     = 3'd1,
		ST_PAST_END  = 3'd2,
		ST_LIMIT     = 3'd3,
		ST_FULL      = 3'd4,
		ST_NOT_FOUND = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_APPLY,
		S_WALK,
		S_DONE
	} state_t;

endpackage

>>> hdl/segment_edit_list_mapper_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// segment_edit_list_mapper_top
// Edit list of source segments with append, clear and frame mapping.
// ---------------------------------------------------------------------------
// Usage: items enter on the s_axis channel; tuser carries the kind (clear,
// append, map output to source, map source to output) and tdata the segment
// or query fields. Every item produces exactly one result item on m_axis,
// carrying the status in tuser and the mapped frame, segment count and total
// frame count in tdata. The two registers are written through cfg_we,
// cfg_index and cfg_data; the user must write them only while the block is
// idle, which the block itself does not enforce. A clear or an append
// passes through the apply state to the done state; a query with a
// negative frame goes straight to the done state. A mapping query walks
// the segment memory one entry per cycle through a read stage and a
// compare stage before it reaches the done state; a hit that ends the
// search early stops the walk there. In the done state the result
// register is loaded once it is free, and the block returns to idle at
// the same edge, ready to accept the next item.
// One item is worked on at a time. The next item is accepted while a result
// still waits in the output register; if the receiver stalls, the block
// finishes that next item and then holds until the output register frees.
// Reset empties the table and clears both registers; the segment memory
// itself is not cleared, since only entries below the count are ever read.
// ---------------------------------------------------------------------------
module segment_edit_list_mapper_top
	import selm_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// Configuration write port.
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	// Input items.
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// tdata: seg_start[31:0], seg_length[63:32], query_frame[95:64],
	//        hint[127:96], forward[128], zero fill [135:129]
	input  logic [S_TDATA_W-1:0]   s_axis_tdata,
	// tuser: kind[1:0]
	input  logic [S_TUSER_W-1:0]   s_axis_tuser,
	// Result items.
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// tdata: mapped_frame[31:0], segments_held[40:32], total_frames[71:41]
	output logic [M_TDATA_W-1:0]   m_axis_tdata,
	// tuser: status[2:0]
	output logic [M_TUSER_W-1:0]   m_axis_tuser
);

	// Configuration registers.
	logic [FRAME_W-1:0] src_count_q;
	logic               exact_q;

	// Control state.
	state_t             state_q, state_d;
	logic [CNT_W-1:0]   count_q;
	logic [FRAME_W-1:0] total_q;

	// The last stored segment is mirrored in registers so that an append
	// never needs a memory read to decide on a merge.
	logic [FRAME_W-1:0] last_start_q;
	logic [FRAME_W-1:0] last_len_q;
	logic [31:0]        last_end_q;

	// Latched item.
	kind_t              kind_q;
	logic [31:0]        start_q;
	logic [31:0]        len_q;
	logic [31:0]        frame_q;
	logic [31:0]        hint_q;
	logic               fwd_q;

	// Walk state.
	logic [CNT_W-1:0]   issue_idx_q;
	logic [FRAME_W-1:0] cursor_q;
	logic [FRAME_W-1:0] rem_q;
	logic               found_q;
	logic [31:0]        best_q;
	logic               v_s1;
	logic               v_s2;
	logic               hit_s2;
	logic [FRAME_W-1:0] val_s2;
	logic [FRAME_W-1:0] cursor_s2;

	// Apply result.
	status_t            res_status_q;

	// Output register.
	logic               m_valid_q;
	status_t            m_status_q;
	logic [31:0]        m_mapped_q;
	logic [CNT_W-1:0]   m_held_q;
	logic [FRAME_W-1:0] m_total_q;

	// Segment memory: entry = {length, start}.
	logic [ENTRY_W-1:0] mem [MAX_SEGMENTS];
	logic [ENTRY_W-1:0] rdata_s1;
	logic               mem_we;
	logic [IDX_W-1:0]   mem_waddr;
	logic [ENTRY_W-1:0] mem_wdata;

	// Control strobes.
	logic               accept;
	logic               out_free;
	logic               issue_en;
	logic               walk_done;
	logic               out_load;
	logic               is_query;

	// Append datapath.
	logic               len_pos;
	logic [32:0]        end33;
	logic [31:0]        tot32;
	logic               merge;
	logic               full;
	logic [CNT_W-1:0]   last_idx;
	logic [FRAME_W-1:0] merged_len;
	status_t            app_status;
	logic               app_commit;

	// Walk datapath.
	logic [FRAME_W-1:0] rd_start;
	logic [FRAME_W-1:0] rd_len;
	logic               hit_s1;
	logic [FRAME_W-1:0] val_s1;
	logic [31:0]        cand;
	logic               cand_ge_hint;
	logic               cand_le_hint;

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_valid_q || m_axis_tready;
	assign is_query = (kind_q == K_OUT2SRC) || (kind_q == K_SRC2OUT);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_count_q <= '0;
			exact_q     <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_SRC_COUNT: src_count_q <= cfg_data;
				CFG_EXACT:     exact_q     <= cfg_data[0];
				default:       ;
			endcase
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (kind_t'(s_axis_tuser))
						K_CLEAR, K_APPEND: state_d = S_APPLY;
						default: begin
							// A negative query frame is never found.
							state_d = s_axis_tdata[95] ? S_DONE : S_WALK;
						end
					endcase
				end
			end
			S_APPLY: state_d = S_DONE;
			S_WALK: begin
				if (walk_done)
					state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control outputs of the state machine.
	always_comb begin
		s_axis_tready = (state_q == S_IDLE);
		issue_en      = (state_q == S_WALK) && !found_q && (issue_idx_q < count_q);
		walk_done     = found_q || ((issue_idx_q == count_q) && !v_s1 && !v_s2);
		out_load      = (state_q == S_DONE) && out_free;
	end

	// Append checks, in the order in which the first failing one wins.
	assign len_pos    = !len_q[31] && (len_q != 32'd0);
	assign end33      = {1'b0, start_q} + {1'b0, len_q};
	assign tot32      = {1'b0, total_q} + len_q;
	assign merge      = (count_q != '0) && (start_q == last_end_q);
	assign full       = (count_q >= CNT_W'(MAX_SEGMENTS));
	assign last_idx   = count_q - CNT_W'(1);
	assign merged_len = last_len_q + len_q[FRAME_W-1:0];

	always_comb begin
		app_status = ST_OK;
		app_commit = 1'b0;
		if (!len_pos)
			app_status = ST_OK;
		else if (start_q[31])
			app_status = ST_RANGE;
		else if (end33 > 33'h0_8000_0000)
			app_status = ST_LIMIT;
		else if (exact_q && (end33 > {2'b00, src_count_q}))
			app_status = ST_PAST_END;
		else if (tot32[31])
			app_status = ST_LIMIT;
		else if (!merge && full)
			app_status = ST_FULL;
		else
			app_commit = 1'b1;
	end

	// Memory write port: a merge rewrites the last entry, a new segment
	// goes behind it.
	always_comb begin
		mem_we    = (state_q == S_APPLY) && (kind_q == K_APPEND) && app_commit;
		mem_waddr = merge ? last_idx[IDX_W-1:0] : count_q[IDX_W-1:0];
		mem_wdata = merge ? {merged_len, last_start_q}
		                  : {len_q[FRAME_W-1:0], start_q[FRAME_W-1:0]};
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (issue_en)
			rdata_s1 <= mem[issue_idx_q[IDX_W-1:0]];
	end

	// Walk, first stage: the entry just read is tested against the query.
	assign rd_start = rdata_s1[FRAME_W-1:0];
	assign rd_len   = rdata_s1[ENTRY_W-1:FRAME_W];

	always_comb begin
		if (kind_q == K_OUT2SRC) begin
			// rem_q is the query frame less the lengths walked so far.
			hit_s1 = (rem_q < rd_len);
			val_s1 = rd_start + rem_q;
		end else begin
			hit_s1 = (frame_q[FRAME_W-1:0] >= rd_start) &&
			         ({1'b0, frame_q[FRAME_W-1:0]} < ({1'b0, rd_start} + {1'b0, rd_len}));
			val_s1 = frame_q[FRAME_W-1:0] - rd_start;
		end
	end

	// Walk, second stage: output position of a source hit against the hint.
	assign cand         = {1'b0, cursor_s2} + {1'b0, val_s2};
	assign cand_ge_hint = $signed({1'b0, cand}) >= $signed({hint_q[31], hint_q});
	assign cand_le_hint = $signed({1'b0, cand}) <= $signed({hint_q[31], hint_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			total_q     <= '0;
			found_q     <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			issue_idx_q <= '0;
			m_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;

			if (accept) begin
				issue_idx_q <= '0;
				found_q     <= 1'b0;
			end else if (issue_en) begin
				issue_idx_q <= issue_idx_q + CNT_W'(1);
			end

			v_s1 <= issue_en;
			v_s2 <= v_s1 && (state_q == S_WALK);

			if ((state_q == S_WALK) && v_s2 && hit_s2 && !found_q) begin
				if ((kind_q == K_OUT2SRC) || (fwd_q && cand_ge_hint))
					found_q <= 1'b1;
			end

			if (state_q == S_APPLY) begin
				if (kind_q == K_CLEAR) begin
					count_q <= '0;
					total_q <= '0;
				end else if (app_commit) begin
					total_q <= tot32[FRAME_W-1:0];
					if (!merge)
						count_q <= count_q + CNT_W'(1);
				end
			end

			if (out_load)
				m_valid_q <= 1'b1;
			else if (m_axis_tready)
				m_valid_q <= 1'b0;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= kind_t'(s_axis_tuser);
			start_q  <= s_axis_tdata[31:0];
			len_q    <= s_axis_tdata[63:32];
			frame_q  <= s_axis_tdata[95:64];
			hint_q   <= s_axis_tdata[127:96];
			fwd_q    <= s_axis_tdata[128];
			cursor_q <= '0;
			rem_q    <= s_axis_tdata[94:64];
			best_q   <= '1;
		end else begin
			if (v_s1) begin
				cursor_q  <= cursor_q + rd_len;
				rem_q     <= rem_q - rd_len;
				hit_s2    <= hit_s1;
				val_s2    <= val_s1;
				cursor_s2 <= cursor_q;
			end
			if ((state_q == S_WALK) && v_s2 && hit_s2 && !found_q) begin
				if (kind_q == K_OUT2SRC)
					best_q <= {1'b0, val_s2};
				else if (fwd_q ? cand_ge_hint : cand_le_hint)
					best_q <= cand;
			end
		end

		if ((state_q == S_APPLY) && (kind_q == K_APPEND) && app_commit) begin
			last_end_q <= end33[31:0];
			if (merge) begin
				last_len_q <= merged_len;
			end else begin
				last_start_q <= start_q[FRAME_W-1:0];
				last_len_q   <= len_q[FRAME_W-1:0];
			end
		end

		if (state_q == S_APPLY)
			res_status_q <= (kind_q == K_APPEND) ? app_status : ST_OK;

		if (out_load) begin
			if (is_query) begin
				m_status_q <= best_q[31] ? ST_NOT_FOUND : ST_OK;
				m_mapped_q <= best_q;
			end else begin
				m_status_q <= res_status_q;
				m_mapped_q <= '1;
			end
			m_held_q  <= count_q;
			m_total_q <= total_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_status_q;
	assign m_axis_tdata  = {m_total_q, SEG_HELD_W'(m_held_q), m_mapped_q};

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_SEGMENTS))
		else $error("segment count beyond table size");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
		((count_q == $past(count_q) + CNT_W'(1)) || (count_q == '0)))
		else $error("segment count changed by more than one append");

	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (!v_s1 && !v_s2))
		else $error("walk pipeline busy while idle");

	a_not_found_value: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && (m_status_q == ST_NOT_FOUND)) |-> (m_mapped_q == 32'hFFFF_FFFF))
		else $error("not found result without minus one");

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_APPLY) && mem_we) |=> (total_q >= $past(total_q)))
		else $error("running total decreased on append");
`endif

endmodule

>>> test/selm_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// selm_checker
// Predicts and checks every result item of the segment edit list mapper.
// ---------------------------------------------------------------------------
// Watches the register write port and both stream channels. Each accepted
// input item is run through a local copy of the segment table, and the
// expected result is queued. Each accepted result item is compared field by
// field with the oldest queued result.
// ---------------------------------------------------------------------------
module selm_checker
	import selm_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	// tdata: seg_start, seg_length, query_frame, hint, forward, zero fill
	input  logic [S_TDATA_W-1:0]   s_axis_tdata,
	// tuser: kind
	input  logic [S_TUSER_W-1:0]   s_axis_tuser,
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// tdata: mapped_frame, segments_held, total_frames
	input  logic [M_TDATA_W-1:0]   m_axis_tdata,
	// tuser: status
	input  logic [M_TUSER_W-1:0]   m_axis_tuser,
	output int                     fail_count,
	output int                     pending,
	output int                     results_seen
);

	typedef struct {
		status_t                 status;
		logic [31:0]             mapped;
		logic [SEG_HELD_W-1:0]   held;
		logic [FRAME_W-1:0]      total;
	} edit_result_t;

	logic [FRAME_W-1:0] tbl_start [MAX_SEGMENTS];
	logic [FRAME_W-1:0] tbl_len   [MAX_SEGMENTS];
	int unsigned        tbl_held;
	logic [FRAME_W-1:0] tbl_total;
	logic [FRAME_W-1:0] src_count;
	logic               exact_mode;

	edit_result_t expected_results [$];

	task automatic report_mismatch(input string msg);
		if (fail_count < 40)
			$display("MISMATCH at %0t ns: %s", $time, msg);
		fail_count++;
	endtask

	function automatic status_t apply_append(input longint start, input longint len);
		longint seg_end;
		bit     joins;
		if (len <= 0)
			return ST_OK;
		joins = tbl_held > 0 &&
			longint'(tbl_start[tbl_held-1]) + longint'(tbl_len[tbl_held-1]) == start;
		if (start < 0)
			return ST_RANGE;
		seg_end = start + len;
		if (seg_end > 64'sh8000_0000)
			return ST_LIMIT;
		if (exact_mode && seg_end > longint'(src_count))
			return ST_PAST_END;
		if (longint'(tbl_total) + len > 64'sh7FFF_FFFF)
			return ST_LIMIT;
		if (joins) begin
			tbl_len[tbl_held-1] += len[FRAME_W-1:0];
		end else begin
			if (tbl_held >= MAX_SEGMENTS)
				return ST_FULL;
			tbl_start[tbl_held] = start[FRAME_W-1:0];
			tbl_len[tbl_held]   = len[FRAME_W-1:0];
			tbl_held++;
		end
		tbl_total += len[FRAME_W-1:0];
		return ST_OK;
	endfunction

	function automatic longint output_to_source(input longint frame);
		longint cursor;
		cursor = 0;
		if (frame < 0)
			return -1;
		for (int i = 0; i < tbl_held; i++) begin
			if (frame < cursor + longint'(tbl_len[i]))
				return longint'(tbl_start[i]) + frame - cursor;
			cursor += longint'(tbl_len[i]);
		end
		return -1;
	endfunction

	function automatic longint source_to_output(input longint frame, input longint hint,
			input bit fwd);
		longint cursor, best, seg_lo, cand;
		cursor = 0;
		best = -1;
		if (frame < 0)
			return -1;
		for (int i = 0; i < tbl_held; i++) begin
			seg_lo = longint'(tbl_start[i]);
			if (frame >= seg_lo && frame < seg_lo + longint'(tbl_len[i])) begin
				cand = cursor + frame - seg_lo;
				if (fwd && cand >= hint)
					return cand;
				if (!fwd && cand <= hint)
					best = cand;
			end
			cursor += longint'(tbl_len[i]);
		end
		return fwd ? -1 : best;
	endfunction

	function automatic edit_result_t predict_edit(input kind_t kind,
			input logic [S_TDATA_W-1:0] data);
		edit_result_t res;
		longint       hit;
		res.status = ST_OK;
		res.mapped = '1;
		case (kind)
			K_CLEAR: begin
				tbl_held  = 0;
				tbl_total = '0;
			end
			K_APPEND: begin
				res.status = apply_append(longint'($signed(data[31:0])),
					longint'($signed(data[63:32])));
			end
			default: begin
				if (kind == K_OUT2SRC)
					hit = output_to_source(longint'($signed(data[95:64])));
				else
					hit = source_to_output(longint'($signed(data[95:64])),
						longint'($signed(data[127:96])), data[128]);
				if (hit < 0)
					res.status = ST_NOT_FOUND;
				else
					res.mapped = hit[31:0];
			end
		endcase
		res.held  = tbl_held[SEG_HELD_W-1:0];
		res.total = tbl_total;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		edit_result_t got;
		edit_result_t want;
		if (!arst_n) begin
			tbl_held     = 0;
			tbl_total    = '0;
			src_count    = '0;
			exact_mode   = 1'b0;
			expected_results.delete();
			fail_count   = 0;
			results_seen = 0;
			pending      = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					CFG_SRC_COUNT: src_count  = cfg_data;
					CFG_EXACT:     exact_mode = cfg_data[0];
					default:       ;
				endcase
			end
			// Results are taken before new items; a result can never belong
			// to an item accepted at the same edge.
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				got.status = status_t'(m_axis_tuser[2:0]);
				got.mapped = m_axis_tdata[31:0];
				got.held   = m_axis_tdata[40:32];
				got.total  = m_axis_tdata[71:41];
				if (expected_results.size() == 0) begin
					report_mismatch("result item arrived with nothing expected");
				end else begin
					want = expected_results.pop_front();
					if (got.status !== want.status)
						report_mismatch($sformatf("status got %0d expected %0d",
							got.status, want.status));
					if (got.mapped !== want.mapped)
						report_mismatch($sformatf("mapped_frame got %0d expected %0d",
							$signed(got.mapped), $signed(want.mapped)));
					if (got.held !== want.held)
						report_mismatch($sformatf("segments_held got %0d expected %0d",
							got.held, want.held));
					if (got.total !== want.total)
						report_mismatch($sformatf("total_frames got %0d expected %0d",
							got.total, want.total));
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_results.push_back(predict_edit(kind_t'(s_axis_tuser[1:0]),
					s_axis_tdata));
			pending = expected_results.size();
		end
	end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the segment edit list mapper.
// ---------------------------------------------------------------------------
// A short directed part walks the append checks, merging, the total limit
// and mapping at the edges of the frame range. A random part then builds
// small edit lists with overlapping source ranges and queries them, fills
// the table to its limit once, mixes in raw noise items and changes the
// registers between phases. The checker beside the block predicts and
// compares every result.
// ---------------------------------------------------------------------------
module testbench;
	import selm_pkg::*;

	localparam int RANDOM_ITEMS   = 700;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int IDLE_PERCENT   = 31;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	// tdata: seg_start, seg_length, query_frame, hint, forward, zero fill
	logic [S_TDATA_W-1:0]   s_axis_tdata;
	// tuser: kind
	logic [S_TUSER_W-1:0]   s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// tdata: mapped_frame, segments_held, total_frames
	logic [M_TDATA_W-1:0]   m_axis_tdata;
	// tuser: status
	logic [M_TUSER_W-1:0]   m_axis_tuser;

	int fail_count;
	int pending;
	int results_seen;

	// calm switches idling off on both sides; hold_req asks the receiver for
	// one long hold-off, which it counts out itself.
	logic calm     = 1'b0;
	logic hold_req = 1'b0;
	int   hold_count = 0;
	int   idle_cycles = 0;

	int     items_sent = 0;
	int     settings_used = 1;
	// Rough record of what the stimulus has built, used only to aim queries and appends.
	longint build_total = 0;
	logic [31:0] last_end = '0;
	bit     have_last = 1'b0;
	bit     table_filled = 1'b0;

	segment_edit_list_mapper_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	selm_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.fail_count    (fail_count),
		.pending       (pending),
		.results_seen  (results_seen)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Receiver: random stalls, except during the hold-off, which has
	// priority, and during the calm stretch.
	always @(negedge clk) begin
		if (hold_req && hold_count < HOLD_CYCLES) begin
			m_axis_tready <= 1'b0;
			hold_count++;
		end else if (calm) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	// Watchdog: any long stretch without a handshake on either channel
	// means the block has hung or dropped an item.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Timeout: no handshake for %0d cycles", idle_cycles);
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Offers one item. Called at a falling edge; returns at the falling edge
	// after the item was accepted, leaving tvalid high so that a following
	// item can go out without a gap.
	task automatic offer(input kind_t kind, input logic [31:0] start, input logic [31:0] len,
			input logic [31:0] frame, input logic [31:0] hint, input logic fwd);
		while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, fwd, hint, frame, len, start};
		s_axis_tuser  <= kind;
		do
			@(posedge clk);
		while (!s_axis_tready);
		items_sent++;
		@(negedge clk);
	endtask

	// The fields an item does not use get random values, so that the block
	// is seen to ignore them.
	task automatic send_clear();
		offer(K_CLEAR, $urandom(), $urandom(), $urandom(), $urandom(), 1'($urandom_range(1)));
		build_total = 0;
		have_last = 1'b0;
	endtask

	task automatic send_append(input logic [31:0] start, input logic [31:0] len);
		offer(K_APPEND, start, len, $urandom(), $urandom(), 1'($urandom_range(1)));
		if ($signed(start) >= 0 && $signed(len) > 0) begin
			build_total += longint'($signed(len));
			last_end = start + len;
			have_last = 1'b1;
		end
	endtask

	task automatic send_out2src(input logic [31:0] frame);
		offer(K_OUT2SRC, $urandom(), $urandom(), frame, $urandom(), 1'($urandom_range(1)));
	endtask

	task automatic send_src2out(input logic [31:0] frame, input logic [31:0] hint,
			input logic fwd);
		offer(K_SRC2OUT, $urandom(), $urandom(), frame, hint, fwd);
	endtask

	// Waits until every expected result has come out, then lets the block
	// settle for the given number of cycles.
	task automatic drain(input int settle);
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	// Writes both registers back to back while the block is idle.
	task automatic reconfigure(input logic [30:0] count, input logic exact);
		drain(8);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_SRC_COUNT;
		cfg_data  <= count;
		@(negedge clk);
		cfg_index <= CFG_EXACT;
		cfg_data  <= {30'd0, exact};
		@(negedge clk);
		cfg_we    <= 1'b0;
		settings_used++;
	endtask

	function automatic logic [31:0] aim_output(input longint span);
		longint top_frame;
		top_frame = (span > 1000) ? 1000 : span;
		return $urandom_range(0, int'(top_frame) + 3);
	endfunction

	task automatic random_queries();
		int          n;
		logic [31:0] frame;
		logic [31:0] hint;
		int          pick;
		n = $urandom_range(1, 6);
		repeat (n) begin
			if ($urandom_range(1)) begin
				pick = $urandom_range(99);
				if (pick < 80)
					frame = aim_output(build_total);
				else if (pick < 90)
					frame = $urandom() | 32'h8000_0000;
				else
					frame = $urandom();
				send_out2src(frame);
			end else begin
				frame = ($urandom_range(99) < 80) ? $urandom_range(0, 90) : $urandom();
				pick = $urandom_range(99);
				if (pick < 60)
					hint = aim_output(build_total);
				else if (pick < 68)
					hint = 32'h8000_0000;
				else if (pick < 75)
					hint = 32'h7FFF_FFFF;
				else
					hint = $urandom();
				send_src2out(frame, hint, 1'($urandom_range(1)));
			end
		end
	endtask

	// A small edit list: source starts come from a narrow pool so that
	// ranges overlap and a source frame often maps to several outputs.
	task automatic random_build();
		int          n;
		int          pick;
		logic [31:0] start;
		logic [31:0] len;
		if ($urandom_range(99) < 70)
			send_clear();
		n = $urandom_range(1, 10);
		repeat (n) begin
			pick = $urandom_range(99);
			if (pick < 25 && have_last) begin
				start = last_end;
				len = $urandom_range(1, 25);
			end else if (pick < 85) begin
				start = $urandom_range(0, 60);
				len = $urandom_range(1, 25);
			end else if (pick < 92) begin
				start = $urandom();
				len = ($urandom_range(1)) ? -$urandom_range(0, 5) : ($urandom() | 32'h8000_0000);
			end else begin
				start = $urandom();
				len = ($urandom_range(1)) ? $urandom_range(1, 40) : $urandom();
			end
			send_append(start, len);
		end
		random_queries();
	endtask

	// Fills the table with segments that never merge, then tries one more
	// separate segment and one that merges into the last entry.
	task automatic fill_table();
		logic [31:0] len;
		logic [31:0] tail;
		longint      tail_total;
		reconfigure(31'h7FFF_FFFF, 1'b1);
		send_clear();
		for (int i = 0; i < MAX_SEGMENTS; i++) begin
			len = $urandom_range(1, 3);
			send_append(i * 4, len);
		end
		// The rejected append below must not move the merge target.
		tail = last_end;
		tail_total = build_total;
		send_append(MAX_SEGMENTS * 4 + 1, 2);
		last_end = tail;
		build_total = tail_total;
		send_append(tail, 3);
		send_out2src(32'(build_total - 1));
		send_out2src(32'(build_total));
		repeat (6) random_queries();
		table_filled = 1'b1;
	endtask

	task automatic random_settings();
		int          pick;
		logic [30:0] count;
		pick = $urandom_range(99);
		if (pick < 30)
			count = 31'h7FFF_FFFF;
		else if (pick < 45)
			count = '0;
		else if (pick < 80)
			count = 31'($urandom_range(40, 120));
		else
			count = 31'($urandom());
		reconfigure(count, 1'($urandom_range(1)));
	endtask

	initial begin : stimulus
		int random_base;
		int pick;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_SRC_COUNT;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = K_CLEAR;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part with the reset settings: no source count enforced.
		send_clear();
		send_out2src(32'd0);                       // empty table
		send_src2out(32'd0, 32'd0, 1'b1);
		send_append(32'h8000_0000, 32'd0);         // zero length is skipped
		send_append(32'h7FFF_FFFF, 32'h8000_0000); // negative length is skipped
		send_append(32'hFFFF_FFFB, 32'd10);        // negative start
		send_append(32'h7FFF_FFFF, 32'd2);         // end past the frame range
		send_append(32'h7FFF_FFFF, 32'd1);         // end exactly at the range edge
		send_append(32'd0, 32'h7FFF_FFFF);         // total over the limit
		send_out2src(32'd0);
		send_src2out(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		send_src2out(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
		send_clear();
		send_append(32'd0, 32'h7FFF_FFFF);         // largest total
		send_append(32'h7FFF_FFFF, 32'd1);         // merge that would overflow
		send_out2src(32'h7FFF_FFFE);
		send_out2src(32'h7FFF_FFFF);
		send_out2src(32'h8000_0000);               // negative query frame

		// Exact source count of 100 frames.
		reconfigure(31'd100, 1'b1);
		send_clear();
		send_append(32'd90, 32'd20);               // past the source end
		send_append(32'd10, 32'd5);
		send_append(32'd15, 32'd5);                // merges
		send_append(32'd40, 32'd60);               // ends on the count
		send_append(32'd10, 32'd20);               // repeats a source range
		send_src2out(32'd12, 32'd0, 1'b1);
		send_src2out(32'd12, 32'h7FFF_FFFF, 1'b0);
		send_append(32'd100, 32'd1);

		reconfigure(31'd0, 1'b0);

		// Random part. The receiver holds off first while items keep coming,
		// so the block fills up and stalls its input.
		random_base = items_sent;
		hold_req <= 1'b1;
		while (items_sent < random_base + RANDOM_ITEMS) begin
			calm <= (items_sent >= random_base + 200 && items_sent < random_base + 330);
			pick = $urandom_range(99);
			if (!table_filled && items_sent >= random_base + 380)
				fill_table();
			else if (pick < 6)
				random_settings();
			else if (pick < 50)
				random_build();
			else if (pick < 88)
				random_queries();
			else
				offer(kind_t'($urandom_range(3)), $urandom(), $urandom(), $urandom(),
					$urandom(), 1'($urandom_range(1)));
		end

		drain(300);
		$display("Sent %0d items and checked %0d results over %0d register settings.",
			items_sent, results_seen, settings_used);
		$display("The run included a full segment table and a receiver hold-off of %0d cycles.",
			HOLD_CYCLES);
		if (fail_count == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

>>> segment_edit_list_mapper_top.f
hdl/selm_pkg.sv
hdl/segment_edit_list_mapper_top.sv
test/selm_checker.sv
test/testbench.sv
